// ----- design/fcpr_pkg.sv -----
// Shared types, constants and response codes of the framed command packet responder.
// No dependencies; every other design file refers to it by scoped names.
package fcpr_pkg;

    localparam int MAX_PAYLOAD_DEF = 16;
    localparam int CHANNELS        = 2;
    localparam int CH_W            = 1;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'h55;
    localparam logic [7:0] ACK_KIND   = 8'h80;
    localparam logic [7:0] NACK_KIND  = 8'hE0;
    localparam logic [7:0] RESP_LEN   = 8'h02;
    localparam logic [7:0] SPEED_MAX  = 8'd100;
    localparam logic [7:0] ERR_LEN    = 8'h01;
    localparam logic [7:0] ERR_CHK    = 8'h02;
    localparam logic [7:0] ERR_CMD    = 8'h03;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_OPCODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_OPCODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_OPCODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIRECTION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIRECTION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MODE   = 3'd6;

    localparam logic [7:0] RST_MOVE_OPCODE    = 8'd1;
    localparam logic [7:0] RST_MODE_OPCODE    = 8'd2;
    localparam logic [7:0] RST_PING_OPCODE    = 8'd3;
    localparam logic [7:0] RST_MAX_DIRECTION  = 8'd4;
    localparam logic [7:0] RST_STOP_DIRECTION = 8'd0;
    localparam logic [7:0] RST_MAX_MODE       = 8'd1;
    localparam logic [7:0] RST_INITIAL_MODE   = 8'd0;

    // Response frame is six bytes; slot 5 carries the end byte.
    localparam logic [2:0] LAST_SLOT = 3'd5;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEN,
        PH_CMD,
        PH_PAY,
        PH_CHK,
        PH_END
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MOVE,
        OP_MODE
    } drive_op_t;

    typedef struct packed {
        logic [7:0] move_opcode;
        logic [7:0] mode_opcode;
        logic [7:0] ping_opcode;
        logic [7:0] max_direction;
        logic [7:0] stop_direction;
        logic [7:0] max_mode;
    } cfg_t;

    // One response to be sent, plus the drive update it carries.
    typedef struct packed {
        logic        channel;
        logic        ack;
        logic [7:0]  code;
        drive_op_t   op;
        logic [7:0]  arg0;
        logic [7:0]  arg1;
        logic [31:0] stamp;
    } resp_desc_t;

endpackage

// ----- design/framed_command_packet_responder_top.sv -----
// Top level of the framed command packet responder: configuration registers,
// frame parser, descriptor queue and response sender. Depends on fcpr_pkg and the fcpr_* modules.
//
//  channel    direction  handshake            payload
//  --------   ---------  -------------------  ------------------------------------------
//  rx         in         push / full          rx_byte, rx_channel, now_ms
//  tx         out        empty / pop          tx_channel, tx_byte, tx_last, drive_direction,
//                                             drive_speed, drive_mode, move_time
//  cfg        in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A received byte is parsed in the cycle it is accepted; up to one byte per cycle while full is low.
// A byte that closes a frame (or carries a bad length) queues one response descriptor;
// each response drains as six transactions, one per cycle while pop is held.
// full rises when the four-entry descriptor queue is occupied; the six-byte frame
// drain of the sender sets the sustained rate for response-causing bytes.
// After reset the parsers wait for a start byte; the drive state holds its reset values.
// cfg_ready is always high; configuration takes effect on the next transaction.
module framed_command_packet_responder_top #(
    parameter int MAX_PAYLOAD = fcpr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // received bytes
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     rx_byte,
    input  logic                           rx_channel,
    input  logic [31:0]                    now_ms,
    // response bytes
    output logic                           empty,
    input  logic                           pop,
    output logic                           tx_channel,
    output logic [7:0]                     tx_byte,
    output logic                           tx_last,
    output logic [7:0]                     drive_direction,
    output logic [6:0]                     drive_speed,
    output logic [7:0]                     drive_mode,
    output logic [31:0]                    move_time,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    fcpr_pkg::cfg_t       cfg_reg;
    fcpr_pkg::resp_desc_t wr_desc;
    fcpr_pkg::resp_desc_t rd_desc;
    logic                 q_wr;
    logic                 q_rd;
    logic                 q_valid;
    logic                 q_full;
    logic                 rx_accept;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign rx_accept = push && !q_full;

    // Configuration registers. initial_mode only matters at reset, where the
    // mode register takes its reset value, so a write to it is taken and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_opcode    <= fcpr_pkg::RST_MOVE_OPCODE;
            cfg_reg.mode_opcode    <= fcpr_pkg::RST_MODE_OPCODE;
            cfg_reg.ping_opcode    <= fcpr_pkg::RST_PING_OPCODE;
            cfg_reg.max_direction  <= fcpr_pkg::RST_MAX_DIRECTION;
            cfg_reg.stop_direction <= fcpr_pkg::RST_STOP_DIRECTION;
            cfg_reg.max_mode       <= fcpr_pkg::RST_MAX_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fcpr_pkg::CFG_MOVE_OPCODE:    cfg_reg.move_opcode    <= cfg_data;
                fcpr_pkg::CFG_MODE_OPCODE:    cfg_reg.mode_opcode    <= cfg_data;
                fcpr_pkg::CFG_PING_OPCODE:    cfg_reg.ping_opcode    <= cfg_data;
                fcpr_pkg::CFG_MAX_DIRECTION:  cfg_reg.max_direction  <= cfg_data;
                fcpr_pkg::CFG_STOP_DIRECTION: cfg_reg.stop_direction <= cfg_data;
                fcpr_pkg::CFG_MAX_MODE:       cfg_reg.max_mode       <= cfg_data;
                fcpr_pkg::CFG_INITIAL_MODE:   cfg_reg                <= cfg_reg;
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front: per-channel frame parsing and classification
    fcpr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (rx_accept),
        .rx_byte    (rx_byte),
        .rx_channel (rx_channel),
        .now_ms     (now_ms),
        .cfg        (cfg_reg),
        .q_wr       (q_wr),
        .q_desc     (wr_desc)
    );

    // Decoupling queue of response descriptors
    fcpr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (wr_desc),
        .rd_en   (q_rd),
        .rd_data (rd_desc),
        .valid   (q_valid),
        .full    (q_full)
    );

    // Back: drive state update and response serialization
    fcpr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_desc          (rd_desc),
        .q_rd            (q_rd),
        .cfg             (cfg_reg),
        .pop             (pop),
        .empty           (empty),
        .tx_channel      (tx_channel),
        .tx_byte         (tx_byte),
        .tx_last         (tx_last),
        .drive_direction (drive_direction),
        .drive_speed     (drive_speed),
        .drive_mode      (drive_mode),
        .move_time       (move_time)
    );

endmodule

// ----- design/fcpr_front.sv -----
// Frame parser: per-channel state machine that turns received bytes into response descriptors.
// Depends on fcpr_pkg.
module fcpr_front #(
    parameter int MAX_PAYLOAD = fcpr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               rx_byte,
    input  logic                     rx_channel,
    input  logic [31:0]              now_ms,
    input  fcpr_pkg::cfg_t           cfg,
    output logic                     q_wr,
    output fcpr_pkg::resp_desc_t     q_desc
);

    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [8:0] LEN_MAX = 9'(MAX_PAYLOAD + 1);

    fcpr_pkg::phase_t phase_reg [fcpr_pkg::CHANNELS];
    logic [PW-1:0]    total_reg [fcpr_pkg::CHANNELS];
    logic [PW-1:0]    pos_reg   [fcpr_pkg::CHANNELS];
    logic [7:0]       cmd_reg   [fcpr_pkg::CHANNELS];
    logic [7:0]       xor_reg   [fcpr_pkg::CHANNELS];
    logic [7:0]       chk_reg   [fcpr_pkg::CHANNELS];
    logic [7:0]       first_reg [fcpr_pkg::CHANNELS];
    logic [7:0]       second_reg[fcpr_pkg::CHANNELS];

    logic [fcpr_pkg::CH_W-1:0] ch;
    logic                      chan_ok;
    logic                      upd;

    fcpr_pkg::phase_t phase_next;
    logic [PW-1:0]    total_next;
    logic [PW-1:0]    pos_next;
    logic [7:0]       cmd_next;
    logic [7:0]       xor_next;
    logic [7:0]       chk_next;
    logic             first_wr;
    logic             second_wr;
    logic             emit;
    logic             ack;
    logic [7:0]       code;
    fcpr_pkg::drive_op_t op;

    assign ch      = rx_channel;
    assign chan_ok = (32'(rx_channel) < 32'(fcpr_pkg::CHANNELS));
    assign upd     = accept && chan_ok;

    always_comb
    begin
        phase_next = phase_reg[ch];
        total_next = total_reg[ch];
        pos_next   = pos_reg[ch];
        cmd_next   = cmd_reg[ch];
        xor_next   = xor_reg[ch];
        chk_next   = chk_reg[ch];
        first_wr   = 1'b0;
        second_wr  = 1'b0;
        emit       = 1'b0;
        ack        = 1'b0;
        code       = fcpr_pkg::ERR_CMD;
        op         = fcpr_pkg::OP_NONE;
        case (phase_reg[ch])
            fcpr_pkg::PH_START:
            begin
                if (rx_byte == fcpr_pkg::START_BYTE)
                begin
                    phase_next = fcpr_pkg::PH_LEN;
                end
            end
            fcpr_pkg::PH_LEN:
            begin
                if (rx_byte == 8'd0 || {1'b0, rx_byte} > LEN_MAX)
                begin
                    phase_next = fcpr_pkg::PH_START;
                    emit       = 1'b1;
                    code       = fcpr_pkg::ERR_LEN;
                end
                else
                begin
                    total_next = PW'(rx_byte - 8'd1);
                    pos_next   = '0;
                    phase_next = fcpr_pkg::PH_CMD;
                end
            end
            fcpr_pkg::PH_CMD:
            begin
                cmd_next   = rx_byte;
                xor_next   = rx_byte;
                phase_next = (total_reg[ch] == '0) ? fcpr_pkg::PH_CHK : fcpr_pkg::PH_PAY;
            end
            fcpr_pkg::PH_PAY:
            begin
                first_wr  = (pos_reg[ch] == PW'(0));
                second_wr = (pos_reg[ch] == PW'(1));
                xor_next  = xor_reg[ch] ^ rx_byte;
                pos_next  = pos_reg[ch] + PW'(1);
                if (pos_next >= total_reg[ch])
                begin
                    phase_next = fcpr_pkg::PH_CHK;
                end
            end
            fcpr_pkg::PH_CHK:
            begin
                chk_next   = rx_byte;
                phase_next = fcpr_pkg::PH_END;
            end
            fcpr_pkg::PH_END:
            begin
                phase_next = fcpr_pkg::PH_START;
                emit       = 1'b1;
                // check mismatch and bad end byte share one error code
                if (rx_byte != fcpr_pkg::END_BYTE || xor_reg[ch] != chk_reg[ch])
                begin
                    code = fcpr_pkg::ERR_CHK;
                end
                else if (cmd_reg[ch] == cfg.move_opcode)
                begin
                    if (total_reg[ch] != PW'(2))
                    begin
                        code = fcpr_pkg::ERR_LEN;
                    end
                    else
                    begin
                        ack  = 1'b1;
                        code = cmd_reg[ch];
                        op   = fcpr_pkg::OP_MOVE;
                    end
                end
                else if (cmd_reg[ch] == cfg.mode_opcode)
                begin
                    if (total_reg[ch] != PW'(1))
                    begin
                        code = fcpr_pkg::ERR_LEN;
                    end
                    else
                    begin
                        ack  = 1'b1;
                        code = cmd_reg[ch];
                        op   = fcpr_pkg::OP_MODE;
                    end
                end
                else if (cmd_reg[ch] == cfg.ping_opcode)
                begin
                    if (total_reg[ch] != '0)
                    begin
                        code = fcpr_pkg::ERR_LEN;
                    end
                    else
                    begin
                        ack  = 1'b1;
                        code = cmd_reg[ch];
                    end
                end
                else
                begin
                    code = fcpr_pkg::ERR_CMD;
                end
            end
            default:
            begin
                phase_next = fcpr_pkg::PH_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fcpr_pkg::CHANNELS; i++)
            begin
                phase_reg[i] <= fcpr_pkg::PH_START;
                total_reg[i] <= '0;
                pos_reg[i]   <= '0;
                cmd_reg[i]   <= '0;
                xor_reg[i]   <= '0;
                chk_reg[i]   <= '0;
            end
        end
        else if (upd)
        begin
            phase_reg[ch] <= phase_next;
            total_reg[ch] <= total_next;
            pos_reg[ch]   <= pos_next;
            cmd_reg[ch]   <= cmd_next;
            xor_reg[ch]   <= xor_next;
            chk_reg[ch]   <= chk_next;
        end
    end

    // payload capture, no reset: written before any frame reads it
    always_ff @(posedge clk)
    begin
        if (upd && first_wr)
        begin
            first_reg[ch] <= rx_byte;
        end
        if (upd && second_wr)
        begin
            second_reg[ch] <= rx_byte;
        end
    end

    assign q_wr           = upd && emit;
    assign q_desc.channel = rx_channel;
    assign q_desc.ack     = ack;
    assign q_desc.code    = code;
    assign q_desc.op      = op;
    assign q_desc.arg0    = first_reg[ch];
    assign q_desc.arg1    = second_reg[ch];
    assign q_desc.stamp   = now_ms;

endmodule

// ----- design/fcpr_queue.sv -----
// Short descriptor queue between the frame parser and the response sender.
// Depends on fcpr_pkg.
module fcpr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  fcpr_pkg::resp_desc_t wr_data,
    input  logic                 rd_en,
    output fcpr_pkg::resp_desc_t rd_data,
    output logic                 valid,
    output logic                 full
);

    localparam int AW = $clog2(fcpr_pkg::QUEUE_DEPTH);

    fcpr_pkg::resp_desc_t mem [fcpr_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;
    logic          do_wr;
    logic          do_rd;

    assign full  = (count_reg == (AW+1)'(fcpr_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(fcpr_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("descriptor written into a full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == (AW+1)'(fcpr_pkg::QUEUE_DEPTH))
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

// ----- design/fcpr_back.sv -----
// Response sender: applies the drive update of each descriptor and sends its six-byte frame.
// Depends on fcpr_pkg.
module fcpr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  fcpr_pkg::resp_desc_t q_desc,
    output logic                 q_rd,
    input  fcpr_pkg::cfg_t       cfg,
    input  logic                 pop,
    output logic                 empty,
    output logic                 tx_channel,
    output logic [7:0]           tx_byte,
    output logic                 tx_last,
    output logic [7:0]           drive_direction,
    output logic [6:0]           drive_speed,
    output logic [7:0]           drive_mode,
    output logic [31:0]          move_time
);

    fcpr_pkg::resp_desc_t desc_reg;
    logic        active_reg;
    logic [2:0]  slot_reg;
    logic [7:0]  dir_reg;
    logic [6:0]  speed_reg;
    logic [7:0]  mode_reg;
    logic [31:0] stamp_reg;

    logic       taken;
    logic       frame_done;
    logic       load;
    logic [7:0] kind;

    assign taken      = pop && active_reg;
    assign frame_done = taken && (slot_reg == fcpr_pkg::LAST_SLOT);
    assign load       = q_valid && (!active_reg || frame_done);
    assign q_rd       = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            slot_reg   <= '0;
            dir_reg    <= fcpr_pkg::RST_STOP_DIRECTION;
            speed_reg  <= '0;
            mode_reg   <= fcpr_pkg::RST_INITIAL_MODE;
            stamp_reg  <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            slot_reg   <= '0;
            if (q_desc.op == fcpr_pkg::OP_MOVE)
            begin
                dir_reg   <= (q_desc.arg0 > cfg.max_direction) ? cfg.stop_direction
                                                                : q_desc.arg0;
                speed_reg <= (q_desc.arg1 > fcpr_pkg::SPEED_MAX) ? fcpr_pkg::SPEED_MAX[6:0]
                                                                  : q_desc.arg1[6:0];
                stamp_reg <= q_desc.stamp;
            end
            else if (q_desc.op == fcpr_pkg::OP_MODE && q_desc.arg0 <= cfg.max_mode)
            begin
                mode_reg <= q_desc.arg0;
            end
        end
        else if (frame_done)
        begin
            active_reg <= 1'b0;
        end
        else if (taken)
        begin
            slot_reg <= slot_reg + 3'd1;
        end
    end

    // descriptor payload, loaded with the frame
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= q_desc;
        end
    end

    assign kind = desc_reg.ack ? fcpr_pkg::ACK_KIND : fcpr_pkg::NACK_KIND;

    always_comb
    begin
        case (slot_reg)
            3'd0:    tx_byte = fcpr_pkg::START_BYTE;
            3'd1:    tx_byte = fcpr_pkg::RESP_LEN;
            3'd2:    tx_byte = kind;
            3'd3:    tx_byte = desc_reg.code;
            3'd4:    tx_byte = kind ^ desc_reg.code;
            default: tx_byte = fcpr_pkg::END_BYTE;
        endcase
    end

    assign empty           = !active_reg;
    assign tx_channel      = desc_reg.channel;
    assign tx_last         = (slot_reg == fcpr_pkg::LAST_SLOT);
    assign drive_direction = dir_reg;
    assign drive_speed     = speed_reg;
    assign drive_mode      = mode_reg;
    assign move_time       = stamp_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> slot_reg <= fcpr_pkg::LAST_SLOT)
        else $error("response slot out of range");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && slot_reg != fcpr_pkg::LAST_SLOT) |=> (active_reg && !empty))
        else $error("frame dropped before its last byte");

    a_speed_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        speed_reg <= fcpr_pkg::SPEED_MAX[6:0])
        else $error("speed above limit");

    a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (active_reg && slot_reg == '0))
        else $error("new frame does not start at its first byte");

endmodule
